// ===== src/xor_polygon_edge_and_fill_engine_assert.svh =====
// Assertion macros shared by the engine's modules.
`ifndef XOR_POLYGON_EDGE_AND_FILL_ENGINE_ASSERT_SVH
`define XOR_POLYGON_EDGE_AND_FILL_ENGINE_ASSERT_SVH
// The consequent holds in the same cycle as the antecedent.
`define XPEF_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// The consequent holds in the cycle after the antecedent.
`define XPEF_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

// ===== src/xpef_pkg.sv =====
// Types and constants shared by the XOR edge and fill engine.
package xpef_pkg;
	localparam int unsigned BufferWidthDef  = 320;
	localparam int unsigned BufferHeightDef = 256;
	localparam int unsigned CoordW     = 11;
	localparam int unsigned YW         = 58;
	localparam int unsigned MW         = 34;
	localparam int unsigned DivNW      = 33;
	localparam int unsigned DivDW      = 25;
	localparam int unsigned MulKW      = 24;
	localparam int unsigned FracW      = 8;
	localparam int unsigned QueueDepth = 4;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_LINE     = 2'd1,
		OP_LINE_SUB = 2'd2,
		OP_FILL     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LINE,
		CMD_FILL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [CoordW-1:0]       x_lo;
		logic [CoordW-1:0]       x_hi;
		logic [CoordW-1:0]       y_lo;
		logic [CoordW-1:0]       y_hi;
		logic signed [YW-1:0]    y_acc;
		logic signed [MW-1:0]    slope;
		logic [7:0]              color;
		logic                    clip;
		logic                    column_start;
		logic                    hit;
	} cmd_t;
endpackage

// ===== src/xpef_item_if.sv =====
// Input item channel of the engine.
interface xpef_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [23:0] x_start;
	logic signed [23:0] y_start;
	logic signed [23:0] x_end;
	logic signed [23:0] y_end;
	logic [7:0]         color;
	logic               clip;
	logic               column_start;

	modport source (output valid, op, x_start, y_start, x_end, y_end, color, clip,
		column_start, input ready);
	modport sink (input valid, op, x_start, y_start, x_end, y_end, color, clip,
		column_start, output ready);
endinterface

// ===== src/xpef_res_if.sv =====
// Result channel of the engine.
interface xpef_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] fill_value;
	logic       visible;

	modport source (output valid, fill_value, visible, input ready);
	modport sink (input valid, fill_value, visible, output ready);
endinterface

// ===== src/xpef_cfg_if.sv =====
// Configuration write channel of the engine.
interface xpef_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== src/xpef_front.sv =====
// Front end: accepts items, classifies them and prepares line setup.
module xpef_front #(
	parameter int unsigned BUFFER_WIDTH  = xpef_pkg::BufferWidthDef,
	parameter int unsigned BUFFER_HEIGHT = xpef_pkg::BufferHeightDef
) (
	input  logic           clk,
	input  logic           arst_n,
	xpef_item_if.sink      items,
	output logic           push_valid,
	input  logic           push_ready,
	output xpef_pkg::cmd_t push_cmd
);
	import xpef_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_SET, S_MUL, S_PUSH} state_t;

	localparam logic signed [24:0] WS = 25'(BUFFER_WIDTH);
	localparam logic signed [24:0] HS = 25'(BUFFER_HEIGHT);

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [DivDW-1:0]     div_q;
	logic [DivDW-1:0]     rem_q;
	logic [DivNW-1:0]     quo_q;
	logic                 neg_q;
	logic [5:0]           cnt_q;
	logic signed [23:0]   c1_q;
	logic signed [23:0]   c2_q;
	logic [FracW-1:0]     frac_q;
	logic signed [YW-1:0] mcand_q;
	logic [MulKW-1:0]     mplier_q;
	logic                 pass_q;

	logic                 sub_n;
	logic signed [24:0]   xs25, ys25, xe25, ye25;
	logic signed [24:0]   xl, xh, yl, yh;
	logic                 clear_ok, fill_hit;
	logic signed [23:0]   ca, cb, x1, y1, x2, y2, c1, c2;
	logic                 swap;
	logic signed [24:0]   dx25, dy25;
	logic [DivDW-1:0]     dy_abs;
	logic signed [YW-1:0] y0_n;
	logic [DivDW:0]       trial;
	logic                 ge;
	logic signed [MW-1:0] m_n;
	logic signed [24:0]   xs_n, xe_n, c1_25, c2_25, k25;

	always_comb begin
		sub_n    = items.op == OP_LINE_SUB;
		xs25     = {items.x_start[23], items.x_start};
		ys25     = {items.y_start[23], items.y_start};
		xe25     = {items.x_end[23], items.x_end};
		ye25     = {items.y_end[23], items.y_end};
		xl       = xs25[24] ? 25'sd0 : xs25;
		yl       = ys25[24] ? 25'sd0 : ys25;
		xh       = (xe25 > WS) ? WS : xe25;
		yh       = (ye25 > HS) ? HS : ye25;
		clear_ok = (xl < xh) && (yl < yh);
		fill_hit = !xs25[24] && (xs25 < WS) && !ys25[24] && (ys25 < HS);
		ca       = sub_n ? (items.x_start >>> 8) : items.x_start;
		cb       = sub_n ? (items.x_end >>> 8) : items.x_end;
		swap     = cb < ca;
		x1       = swap ? items.x_end : items.x_start;
		y1       = swap ? items.y_end : items.y_start;
		x2       = swap ? items.x_start : items.x_end;
		y2       = swap ? items.y_start : items.y_end;
		c1       = swap ? cb : ca;
		c2       = swap ? ca : cb;
		dx25     = {x2[23], x2} - {x1[23], x1};
		dy25     = {y2[23], y2} - {y1[23], y1};
		dy_abs   = dy25[24] ? DivDW'(-dy25) : DivDW'(dy25);
		y0_n     = {{(YW-24){y1[23]}}, y1};
		if (!sub_n) begin
			y0_n = y0_n <<< 8;
		end
		trial = {rem_q, quo_q[DivNW-1]};
		ge    = trial >= {1'b0, div_q};
		m_n   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		c1_25 = {c1_q[23], c1_q};
		c2_25 = {c2_q[23], c2_q};
		xs_n  = c1_q[23] ? 25'sd0 : c1_25;
		xe_n  = (c2_25 > WS) ? WS : c2_25;
		k25   = xs_n - c1_25;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			div_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			c1_q     <= '0;
			c2_q     <= '0;
			frac_q   <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			pass_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (items.valid) begin
						cmd_q.color        <= items.color;
						cmd_q.clip         <= items.clip;
						cmd_q.column_start <= items.column_start;
						cmd_q.hit          <= fill_hit;
						cmd_q.slope        <= '0;
						cmd_q.y_acc        <= y0_n;
						case (items.op)
							OP_CLEAR: begin
								cmd_q.kind <= clear_ok ? CMD_CLEAR : CMD_NONE;
								cmd_q.x_lo <= xl[CoordW-1:0];
								cmd_q.x_hi <= xh[CoordW-1:0];
								cmd_q.y_lo <= yl[CoordW-1:0];
								cmd_q.y_hi <= yh[CoordW-1:0];
								state_q    <= S_PUSH;
							end
							OP_FILL: begin
								cmd_q.kind <= CMD_FILL;
								cmd_q.x_lo <= items.x_start[CoordW-1:0];
								cmd_q.y_lo <= items.y_start[CoordW-1:0];
								state_q    <= S_PUSH;
							end
							default: begin
								if (ca == cb) begin
									cmd_q.kind <= CMD_NONE;
									state_q    <= S_PUSH;
								end else begin
									cmd_q.kind <= CMD_LINE;
									div_q      <= DivDW'(dx25);
									rem_q      <= '0;
									quo_q      <= {dy_abs, 8'd0};
									neg_q      <= dy25[24];
									cnt_q      <= 6'(DivNW);
									c1_q       <= c1;
									c2_q       <= c2;
									frac_q     <= sub_n ? ~x1[7:0] : 8'd0;
									state_q    <= S_DIV;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					rem_q <= ge ? DivDW'(trial - {1'b0, div_q}) : trial[DivDW-1:0];
					quo_q <= {quo_q[DivNW-2:0], ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= S_SET;
					end
				end
				S_SET: begin
					if (xs_n >= xe_n) begin
						cmd_q.kind <= CMD_NONE;
						state_q    <= S_PUSH;
					end else begin
						cmd_q.x_lo  <= xs_n[CoordW-1:0];
						cmd_q.x_hi  <= xe_n[CoordW-1:0];
						cmd_q.slope <= m_n;
						mcand_q     <= {{(YW-MW){m_n[MW-1]}}, m_n};
						mplier_q    <= k25[MulKW-1:0];
						cnt_q       <= 6'(MulKW);
						pass_q      <= 1'b0;
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mplier_q[0]) begin
						cmd_q.y_acc <= cmd_q.y_acc + mcand_q;
					end
					if (cnt_q == 6'd1 && !pass_q) begin
						mcand_q  <= {{(YW-MW){cmd_q.slope[MW-1]}}, cmd_q.slope >>> 8};
						mplier_q <= {{(MulKW-FracW){1'b0}}, frac_q};
						cnt_q    <= 6'(FracW);
						pass_q   <= 1'b1;
					end else begin
						mcand_q  <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
						cnt_q    <= cnt_q - 6'd1;
						if (cnt_q == 6'd1) begin
							state_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign items.ready = state_q == S_IDLE;
	assign push_valid  = state_q == S_PUSH;
	assign push_cmd    = cmd_q;
endmodule

// ===== src/xpef_queue.sv =====
// Short command queue between the front and back ends.
`include "xor_polygon_edge_and_fill_engine_assert.svh"
module xpef_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  xpef_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output xpef_pkg::cmd_t pop_cmd
);
	import xpef_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	cmd_t            store_q [QueueDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;

	assign push_ready = count_q != CntW'(QueueDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`XPEF_ASSERT_IMP(a_count_max, 1'b1, count_q <= CntW'(QueueDepth))
	`XPEF_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
	`XPEF_ASSERT_NXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1)
endmodule

// ===== src/xpef_back.sv =====
// Back end: executes commands against the frame store and returns results.
`include "xor_polygon_edge_and_fill_engine_assert.svh"
module xpef_back #(
	parameter int unsigned BUFFER_WIDTH  = xpef_pkg::BufferWidthDef,
	parameter int unsigned BUFFER_HEIGHT = xpef_pkg::BufferHeightDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           skip_zero_color,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  xpef_pkg::cmd_t cmd_in,
	xpef_res_if.source     results
);
	import xpef_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_CLEAR, B_LRD, B_LWR, B_FRD, B_FWR, B_RES} state_t;

	localparam int unsigned Depth = BUFFER_WIDTH * BUFFER_HEIGHT;
	localparam int unsigned AW    = $clog2(Depth);
	localparam int unsigned FullW = 2 * CoordW;

	logic [7:0]           mem [Depth];
	logic [7:0]           rdata_q;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [CoordW-1:0]    cx_q;
	logic [CoordW-1:0]    cy_q;
	logic signed [YW-1:0] y_q;
	logic [7:0]           acc_q;
	logic [7:0]           res_val_q;
	logic                 res_vis_q;
	logic                 out_valid_q;
	logic [7:0]           out_val_q;
	logic                 out_vis_q;

	logic                 row_neg, row_big, draw_ok;
	logic [CoordW-1:0]    row_eff, ax, ay;
	logic [FullW-1:0]     addr_full;
	logic [AW-1:0]        addr;
	logic                 we;
	logic [7:0]           wdata;
	logic [7:0]           acc_new;

	always_comb begin
		row_neg = y_q[YW-1];
		row_big = y_q[YW-2:8] >= (YW-9)'(BUFFER_HEIGHT);
		draw_ok = row_neg ? cmd_q.clip : !row_big;
		row_eff = row_neg ? '0 : y_q[8+CoordW-1:8];
		acc_new = acc_q ^ rdata_q;
		ax      = cx_q;
		ay      = cy_q;
		we      = 1'b0;
		wdata   = cmd_q.color;
		case (state_q)
			B_CLEAR: begin
				we = 1'b1;
			end
			B_LRD: begin
				ay = row_eff;
			end
			B_LWR: begin
				ay    = row_eff;
				we    = draw_ok;
				wdata = rdata_q ^ cmd_q.color;
			end
			B_FRD: begin
				ax = cmd_q.x_lo;
				ay = cmd_q.y_lo;
			end
			B_FWR: begin
				ax    = cmd_q.x_lo;
				ay    = cmd_q.y_lo;
				we    = 1'b1;
				wdata = acc_new;
			end
			default: ;
		endcase
		addr_full = {{CoordW{1'b0}}, ay} * FullW'(BUFFER_WIDTH) + FullW'(ax);
		addr      = addr_full[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			y_q         <= '0;
			acc_q       <= '0;
			res_val_q   <= '0;
			res_vis_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_vis_q   <= 1'b0;
		end else begin
			if (results.ready && state_q != B_RES) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q     <= cmd_in;
						cx_q      <= cmd_in.x_lo;
						cy_q      <= cmd_in.y_lo;
						y_q       <= cmd_in.y_acc;
						res_val_q <= '0;
						res_vis_q <= 1'b0;
						case (cmd_in.kind)
							CMD_CLEAR: state_q <= B_CLEAR;
							CMD_LINE:  state_q <= B_LRD;
							CMD_FILL: begin
								if (cmd_in.column_start) begin
									acc_q <= '0;
								end
								state_q <= cmd_in.hit ? B_FRD : B_RES;
							end
							default:   state_q <= B_RES;
						endcase
					end
				end
				B_CLEAR: begin
					if (cx_q + 1'b1 == cmd_q.x_hi) begin
						cx_q <= cmd_q.x_lo;
						cy_q <= cy_q + 1'b1;
						if (cy_q + 1'b1 == cmd_q.y_hi) begin
							state_q <= B_RES;
						end
					end else begin
						cx_q <= cx_q + 1'b1;
					end
				end
				B_LRD: state_q <= B_LWR;
				B_LWR: begin
					cx_q <= cx_q + 1'b1;
					y_q  <= y_q + {{(YW-MW){cmd_q.slope[MW-1]}}, cmd_q.slope};
					state_q <= (cx_q + 1'b1 == cmd_q.x_hi) ? B_RES : B_LRD;
				end
				B_FRD: state_q <= B_FWR;
				B_FWR: begin
					acc_q     <= acc_new;
					res_val_q <= acc_new;
					res_vis_q <= !skip_zero_color || (acc_new != 8'd0);
					state_q   <= B_RES;
				end
				B_RES: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_vis_q   <= res_vis_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign cmd_ready          = state_q == B_IDLE;
	assign results.valid      = out_valid_q;
	assign results.fill_value = out_val_q;
	assign results.visible    = out_vis_q;

	`XPEF_ASSERT_IMP(a_write_state, we, state_q == B_CLEAR || state_q == B_LWR || state_q == B_FWR)
	`XPEF_ASSERT_NXT(a_take_leaves_idle, cmd_valid && cmd_ready, state_q != B_IDLE)
	`XPEF_ASSERT_NXT(a_result_waits, state_q == B_RES && out_valid_q && !results.ready, state_q == B_RES)
endmodule

// ===== src/xor_polygon_edge_and_fill_engine.sv =====
// Each transfer on items gives exactly one transfer on results, in order. A fill step on a hit
// reads and then writes one frame store cell; a clear writes each pixel of the clipped rectangle,
// and a line is first set up in the front end (a 33-step divider for the slope and a 32-step
// shift-add for the start row) and then does a read and then a write on the single frame store
// port for each clipped column. A four-entry command queue lets the front end set up the next
// item while the back end works.
module xor_polygon_edge_and_fill_engine #(
	parameter int unsigned BUFFER_WIDTH  = xpef_pkg::BufferWidthDef,
	parameter int unsigned BUFFER_HEIGHT = xpef_pkg::BufferHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	xpef_cfg_if.sink    cfg,
	xpef_item_if.sink   items,
	xpef_res_if.source  results
);
	import xpef_pkg::*;

	logic skip_q;
	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, b_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (cfg.valid) begin
			skip_q <= cfg.data;
		end
	end

	xpef_front #(.BUFFER_WIDTH(BUFFER_WIDTH), .BUFFER_HEIGHT(BUFFER_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .items(items),
		.push_valid(f_valid), .push_ready(f_ready), .push_cmd(f_cmd)
	);

	xpef_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_cmd(f_cmd),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_cmd(b_cmd)
	);

	xpef_back #(.BUFFER_WIDTH(BUFFER_WIDTH), .BUFFER_HEIGHT(BUFFER_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .skip_zero_color(skip_q),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_in(b_cmd),
		.results(results)
	);
endmodule
